/* hw/rtl/wts_pkg.sv */
// Shared types and constants for the windowed track statistics block.
// Used by window_track_statistics, wts_front and wts_back; depends on nothing.
package wts_pkg;

  localparam int WIN_W     = 13;  // window_start / window_end
  localparam int FRAC_W    = 17;  // threshold fraction, Q1.16 unsigned
  localparam int LEN_W     = 17;  // track length, wide enough for any supported depth
  localparam int STAT_W    = 40;  // result value
  localparam int CODE_W    = 4;   // result code
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;  // widest configuration register
  localparam int THR_SHIFT = 16;
  localparam int ROUND_BIAS = 32768;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FRAC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_MODE  = 2'd3;

  localparam logic [WIN_W-1:0] WIN_END_RST = 13'd4096;

  // Result codes
  localparam logic [CODE_W-1:0] STAT_MAX       = 4'd0;
  localparam logic [CODE_W-1:0] STAT_MAX_POS   = 4'd1;
  localparam logic [CODE_W-1:0] STAT_MAX_VAR   = 4'd2;
  localparam logic [CODE_W-1:0] STAT_MIN       = 4'd3;
  localparam logic [CODE_W-1:0] STAT_MIN_POS   = 4'd4;
  localparam logic [CODE_W-1:0] STAT_MIN_VAR   = 4'd5;
  localparam logic [CODE_W-1:0] STAT_AREA      = 4'd6;
  localparam logic [CODE_W-1:0] STAT_AREA_VAR  = 4'd7;
  localparam logic [CODE_W-1:0] STAT_EARLY     = 4'd8;
  localparam logic [CODE_W-1:0] STAT_EARLY_VAR = 4'd9;
  localparam logic [CODE_W-1:0] STAT_LATE      = 4'd10;
  localparam logic [CODE_W-1:0] STAT_LATE_VAR  = 4'd11;
  localparam logic [CODE_W-1:0] STAT_THRESHOLD = 4'd12;

  // Q.8 constants
  localparam logic signed [STAT_W-1:0] VAL_PLUS_100  = 40'sd25600;
  localparam logic signed [STAT_W-1:0] VAL_MINUS_100 = -40'sd25600;
  localparam logic signed [STAT_W-1:0] VAL_MINUS_ONE = -40'sd256;

  // One finished track handed from front to back
  typedef struct packed {
    logic              bank;
    logic [WIN_W-1:0]  win_start;
    logic [WIN_W-1:0]  win_end;
    logic [LEN_W-1:0]  count;
    logic [FRAC_W-1:0] frac;
    logic              err;
  } job_t;

  // Sample bank handed back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [CODE_W-1:0]        stat_code;
    logic signed [STAT_W-1:0] stat_value;
    logic                     last_stat;
  } result_t;

endpackage

/* hw/rtl/window_track_statistics.sv */
// Top level of the windowed track statistics block.
// Depends on wts_pkg, wts_fifo, wts_front and wts_back.
//
// Samples stream in one per cycle through in_push/in_full and are numbered
// from 0 within a track. The front end writes each sample into one of two
// sample banks (MAX_TRACK_LEN entries each; positions beyond that saturate
// and are not stored) and, on the sample marked last, hands the track as a
// job to the back end through a two-entry job queue and switches to the
// other bank, so the next track streams in without a gap. The back end
// sweeps the window [window_start, min(window_end, length)) at one memory
// read per cycle, tracking max and min (first occurrence wins), the
// variance at each, the total sum and the early-third and late-third sums,
// then forms threshold_fraction * (max - min) rounded to Q.8 and pushes 13
// results into a two-entry result queue, code 0 first and the threshold,
// with last_stat set, last. For each track the back end runs the sweep,
// then the math, then the result run; the single read port of the sample
// memory sets the sweep rate. in_full rises only when the bank the next
// sample would go to still holds a track that the back end has not swept.
// Configuration is sampled on the last sample of each track. The sample
// memory needs no clearing pass: only entries of the current track are
// ever read.
module window_track_statistics #(
  parameter int MAX_TRACK_LEN = 4096,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample input
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample_value,
  input  logic [SAMPLE_WIDTH-1:0]              in_sample_variance,
  input  logic                                 in_last_sample,
  // result output
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [wts_pkg::CODE_W-1:0]           out_stat_code,
  output logic signed [wts_pkg::STAT_W-1:0]    out_stat_value,
  output logic                                 out_last_stat,
  // configuration
  input  logic                                 cfg_we,
  input  logic [wts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wts_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int AW = $clog2(MAX_TRACK_LEN);

  logic [wts_pkg::WIN_W-1:0]  win_start_r, win_end_r;
  logic [wts_pkg::FRAC_W-1:0] frac_r;
  logic                       err_r;

  wts_pkg::job_t              job_in, job_out;
  logic                       job_push, job_full, job_pop, job_empty;
  wts_pkg::bank_rel_t         rel;
  logic                       rd_en;
  logic [AW:0]                rd_addr;
  logic signed [SAMPLE_WIDTH-1:0] rd_value;
  logic [SAMPLE_WIDTH-1:0]    rd_variance;
  wts_pkg::result_t           res_in, res_out;
  logic                       res_push, res_full;

  // Configuration is write-only; user writes only while idle; not checked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= wts_pkg::WIN_END_RST;
      frac_r      <= '0;
      err_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wts_pkg::REG_WIN_START: win_start_r <= cfg_wdata[wts_pkg::WIN_W-1:0];
        wts_pkg::REG_WIN_END:   win_end_r   <= cfg_wdata[wts_pkg::WIN_W-1:0];
        wts_pkg::REG_THR_FRAC:  frac_r      <= cfg_wdata[wts_pkg::FRAC_W-1:0];
        wts_pkg::REG_ERR_MODE:  err_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Front: count positions, store samples, hand off finished tracks
  wts_front #(
    .MAX_TRACK_LEN (MAX_TRACK_LEN),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_sample_value    (in_sample_value),
    .in_sample_variance (in_sample_variance),
    .in_last_sample     (in_last_sample),
    .win_start          (win_start_r),
    .win_end            (win_end_r),
    .frac               (frac_r),
    .err                (err_r),
    .job_push           (job_push),
    .job_data           (job_in),
    .job_full           (job_full),
    .rel                (rel),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_value           (rd_value),
    .rd_variance        (rd_variance)
  );

  // Job queue: one entry per sample bank
  wts_fifo #(
    .item_t (wts_pkg::job_t),
    .DEPTH  (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  // Back: sweep the window, accumulate, emit the result run
  wts_back #(
    .MAX_TRACK_LEN (MAX_TRACK_LEN),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .job_data    (job_out),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_value    (rd_value),
    .rd_variance (rd_variance),
    .rel         (rel),
    .res_push    (res_push),
    .res_data    (res_in),
    .res_full    (res_full)
  );

  // Result queue: hold finished words until the consumer pops them
  wts_fifo #(
    .item_t (wts_pkg::result_t),
    .DEPTH  (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_stat_code  = res_out.stat_code;
  assign out_stat_value = res_out.stat_value;
  assign out_last_stat  = res_out.last_stat;

endmodule

/* hw/rtl/wts_fifo.sv */
// Small register queue with push/full and pop/empty handshakes.
// Item type comes in as a parameter; no package dependency.
module wts_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

/* hw/rtl/wts_front.sv */
// Sample intake: position counting, two-bank sample memory, job handoff.
// Depends on wts_pkg (job_t, bank_rel_t, widths).
module wts_front #(
  parameter int MAX_TRACK_LEN = 4096,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_value,
  input  logic [SAMPLE_WIDTH-1:0]             in_sample_variance,
  input  logic                                in_last_sample,
  input  logic [wts_pkg::WIN_W-1:0]           win_start,
  input  logic [wts_pkg::WIN_W-1:0]           win_end,
  input  logic [wts_pkg::FRAC_W-1:0]          frac,
  input  logic                                err,
  output logic                                job_push,
  output wts_pkg::job_t                       job_data,
  input  logic                                job_full,
  input  wts_pkg::bank_rel_t                  rel,
  input  logic                                rd_en,
  input  logic [$clog2(MAX_TRACK_LEN):0]      rd_addr,
  output logic signed [SAMPLE_WIDTH-1:0]      rd_value,
  output logic [SAMPLE_WIDTH-1:0]             rd_variance
);

  localparam int AW    = $clog2(MAX_TRACK_LEN);
  localparam int CW    = $clog2(MAX_TRACK_LEN + 1);
  localparam int DEPTH = 2 * MAX_TRACK_LEN;

  logic [2*SAMPLE_WIDTH-1:0] sample_mem [DEPTH];
  logic [2*SAMPLE_WIDTH-1:0] rd_q_r;
  logic [CW-1:0]             count_r, count_nxt, count_end;
  logic                      wbank_r, wbank_nxt;
  logic [1:0]                busy_r, busy_nxt;
  logic                      accept, room, store;

  assign in_full   = busy_r[wbank_r] | job_full;
  assign accept    = in_push & ~in_full;
  assign room      = (count_r < CW'(MAX_TRACK_LEN));
  assign store     = accept & room;
  assign count_end = room ? count_r + CW'(1) : count_r;
  assign job_push  = accept & in_last_sample;

  always_comb begin
    job_data           = '0;
    job_data.bank      = wbank_r;
    job_data.win_start = win_start;
    job_data.win_end   = win_end;
    job_data.count     = wts_pkg::LEN_W'(count_end);
    job_data.frac      = frac;
    job_data.err       = err;
  end

  always_comb begin
    count_nxt = count_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    if (accept) count_nxt = in_last_sample ? '0 : count_end;
    if (rel.valid) busy_nxt[rel.bank] = 1'b0;
    if (job_push) begin
      // bank now belongs to the back end; switch writes to the other one
      busy_nxt[wbank_r] = 1'b1;
      wbank_nxt         = ~wbank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      count_r <= count_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) sample_mem[{wbank_r, count_r[AW-1:0]}] <= {in_sample_value, in_sample_variance};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q_r <= sample_mem[rd_addr];
  end

  assign rd_value    = $signed(rd_q_r[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
  assign rd_variance = rd_q_r[SAMPLE_WIDTH-1:0];

endmodule

/* hw/rtl/wts_back.sv */
// Window sweep over a stored track, statistics accumulation and result run.
// Depends on wts_pkg (job_t, bank_rel_t, result_t, codes, constants).
module wts_back #(
  parameter int MAX_TRACK_LEN = 4096,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_empty,
  output logic                            job_pop,
  input  wts_pkg::job_t                   job_data,
  output logic                            rd_en,
  output logic [$clog2(MAX_TRACK_LEN):0]  rd_addr,
  input  logic signed [SAMPLE_WIDTH-1:0]  rd_value,
  input  logic [SAMPLE_WIDTH-1:0]         rd_variance,
  output wts_pkg::bank_rel_t              rel,
  output logic                            res_push,
  output wts_pkg::result_t                res_data,
  input  logic                            res_full
);

  localparam int AW     = $clog2(MAX_TRACK_LEN);
  localparam int CW     = $clog2(MAX_TRACK_LEN + 1);
  localparam int PW     = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
  localparam int XW     = ((wts_pkg::WIN_W > CW) ? wts_pkg::WIN_W : CW) + 2;
  localparam int PROD_W = wts_pkg::FRAC_W + 1 + PW + 1;
  localparam int SW_    = wts_pkg::STAT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic [wts_pkg::CODE_W-1:0]    emit_r, emit_nxt;
  logic                          s1_vld_r, s1_vld_nxt;
  logic                          s1_first_r, s1_first_nxt;
  logic                          s1_early_r, s1_late_r;
  logic [AW-1:0]                 s1_pos_r;
  wts_pkg::job_t                 job_r;
  logic [CW-1:0]                 b_r, j_r;
  logic [XW-1:0]                 x1_r, x2_r, j3_r, a_x, b_x;
  logic [wts_pkg::LEN_W-1:0]     end_ext, b_full;
  logic signed [PW-1:0]          peak_r, trough_r, v_ext;
  logic [AW-1:0]                 peak_pos_r, trough_pos_r;
  logic [SAMPLE_WIDTH-1:0]       peak_var_r, trough_var_r;
  logic signed [SW_-1:0]         total_r, tvar_r, early_r, evar_r, late_r, lvar_r;
  logic signed [SW_-1:0]         v_stat, e_stat, var_init;
  logic signed [PW:0]            diff_r;
  logic signed [PROD_W-1:0]      prod_r, prod_rnd;
  logic signed [SW_-1:0]         thr;
  logic                          win_empty, sweep_done;

  assign end_ext    = wts_pkg::LEN_W'(job_data.win_end);
  assign b_full     = (end_ext < job_data.count) ? end_ext : job_data.count;
  assign a_x        = XW'(job_r.win_start);
  assign b_x        = XW'(b_r);
  assign win_empty  = ~(a_x < b_x);
  assign sweep_done = (j_r + CW'(1) == b_r);

  assign job_pop  = (state_r == ST_IDLE) & ~job_empty;
  assign rd_en    = (state_r == ST_START) | (state_r == ST_SWEEP);
  assign rd_addr  = {job_r.bank, (state_r == ST_START) ? AW'(0) : j_r[AW-1:0]};
  assign rel.valid = (state_r == ST_DRAIN);
  assign rel.bank  = job_r.bank;
  assign res_push = (state_r == ST_EMIT) & ~res_full;

  assign v_ext    = PW'(rd_value);
  assign v_stat   = SW_'(rd_value);
  assign e_stat   = SW_'(rd_variance);
  assign var_init = job_r.err ? '0 : wts_pkg::VAL_MINUS_ONE;
  assign prod_rnd = prod_r + PROD_W'(wts_pkg::ROUND_BIAS);
  assign thr      = SW_'(prod_rnd >>> wts_pkg::THR_SHIFT);

  always_comb begin
    state_nxt    = state_r;
    emit_nxt     = emit_r;
    s1_vld_nxt   = (state_r == ST_SWEEP);
    s1_first_nxt = (state_r == ST_START);
    unique case (state_r)
      ST_IDLE:  if (!job_empty) state_nxt = ST_START;
      ST_START: begin
        emit_nxt  = '0;
        state_nxt = win_empty ? ST_DRAIN : ST_SWEEP;
      end
      ST_SWEEP: if (sweep_done) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (res_push) begin
          if (emit_r == wts_pkg::STAT_THRESHOLD) begin
            emit_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + wts_pkg::CODE_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      emit_r     <= '0;
      s1_vld_r   <= 1'b0;
      s1_first_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emit_r     <= emit_nxt;
      s1_vld_r   <= s1_vld_nxt;
      s1_first_r <= s1_first_nxt;
    end
  end

  // Address generation and thirds classification
  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_data;
      b_r   <= CW'(b_full);
    end
    if (state_r == ST_START) begin
      x1_r <= (a_x << 1) + b_x;
      x2_r <= a_x + (b_x << 1);
      j_r  <= CW'(job_r.win_start);
      j3_r <= (a_x << 1) + a_x;
    end
    if (state_r == ST_SWEEP) begin
      // early when 3(j+1) <= 2A+B, late when 3j > A+2B
      s1_pos_r   <= j_r[AW-1:0];
      s1_early_r <= (j3_r + XW'(3) <= x1_r);
      s1_late_r  <= (j3_r > x2_r);
      j_r        <= j_r + CW'(1);
      j3_r       <= j3_r + XW'(3);
    end
  end

  // Accumulators, fed one sample behind the read address
  always_ff @(posedge clk) begin
    if (state_r == ST_START) begin
      peak_r       <= PW'(wts_pkg::VAL_MINUS_100);
      trough_r     <= PW'(wts_pkg::VAL_PLUS_100);
      peak_pos_r   <= '0;
      trough_pos_r <= '0;
      total_r      <= '0;
      early_r      <= '0;
      late_r       <= '0;
      tvar_r       <= var_init;
      evar_r       <= var_init;
      lvar_r       <= var_init;
    end else begin
      if (s1_first_r) begin
        peak_var_r   <= rd_variance;
        trough_var_r <= rd_variance;
      end
      if (s1_vld_r) begin
        if (v_ext > peak_r) begin
          peak_r     <= v_ext;
          peak_pos_r <= s1_pos_r;
          peak_var_r <= rd_variance;
        end
        if (v_ext < trough_r) begin
          trough_r     <= v_ext;
          trough_pos_r <= s1_pos_r;
          trough_var_r <= rd_variance;
        end
        total_r <= total_r + v_stat;
        if (job_r.err) tvar_r <= tvar_r + e_stat;
        if (s1_early_r) begin
          early_r <= early_r + v_stat;
          if (job_r.err) evar_r <= evar_r + e_stat;
        end
        if (s1_late_r) begin
          late_r <= late_r + v_stat;
          if (job_r.err) lvar_r <= lvar_r + e_stat;
        end
      end
    end
    if (state_r == ST_DIFF) diff_r <= (PW + 1)'(peak_r) - (PW + 1)'(trough_r);
    if (state_r == ST_MUL) prod_r <= $signed({1'b0, job_r.frac}) * diff_r;
  end

  always_comb begin
    res_data           = '0;
    res_data.stat_code = emit_r;
    res_data.last_stat = (emit_r == wts_pkg::STAT_THRESHOLD);
    case (emit_r)
      wts_pkg::STAT_MAX:       res_data.stat_value = SW_'(peak_r);
      wts_pkg::STAT_MAX_POS:   res_data.stat_value = SW_'(peak_pos_r);
      wts_pkg::STAT_MAX_VAR:   res_data.stat_value = job_r.err ? SW_'(peak_var_r)
                                                               : wts_pkg::VAL_MINUS_ONE;
      wts_pkg::STAT_MIN:       res_data.stat_value = SW_'(trough_r);
      wts_pkg::STAT_MIN_POS:   res_data.stat_value = SW_'(trough_pos_r);
      wts_pkg::STAT_MIN_VAR:   res_data.stat_value = job_r.err ? SW_'(trough_var_r)
                                                               : wts_pkg::VAL_MINUS_ONE;
      wts_pkg::STAT_AREA:      res_data.stat_value = total_r;
      wts_pkg::STAT_AREA_VAR:  res_data.stat_value = tvar_r;
      wts_pkg::STAT_EARLY:     res_data.stat_value = early_r;
      wts_pkg::STAT_EARLY_VAR: res_data.stat_value = evar_r;
      wts_pkg::STAT_LATE:      res_data.stat_value = late_r;
      wts_pkg::STAT_LATE_VAR:  res_data.stat_value = lvar_r;
      wts_pkg::STAT_THRESHOLD: res_data.stat_value = thr;
      default:                 res_data.stat_value = '0;
    endcase
  end

endmodule
